[hdl/xml_text_escaper_top_defines.svh]
// Assertion macros used by the checker file of the escaper.
`ifndef XML_TEXT_ESCAPER_TOP_DEFINES_SVH
`define XML_TEXT_ESCAPER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge and quiet in reset.
`define XTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and quiet in reset.
`define XTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/xte_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package xte_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned RUN_W  = 2;
    localparam int unsigned ENT_W  = 48;

    localparam logic [KIND_W-1:0] KIND_PLAIN = 3'd0;
    localparam logic [KIND_W-1:0] KIND_AMP   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_QUOT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GT    = 3'd4;

    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_AMP     = 8'h26;
    localparam logic [BYTE_W-1:0] CH_LT      = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT      = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_QUOT    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_RBRACK  = 8'h5D;

    // Entity texts, right aligned, first character in the highest used byte.
    localparam logic [ENT_W-1:0] ENT_AMP  = {8'h00, "&amp;"};
    localparam logic [ENT_W-1:0] ENT_LT   = {16'h0000, "&lt;"};
    localparam logic [ENT_W-1:0] ENT_QUOT = "&quot;";
    localparam logic [ENT_W-1:0] ENT_GT   = {16'h0000, "&gt;"};

    localparam logic [RUN_W-1:0] RUN_MAX = 2'd2;

    // Classification of one accepted item.
    typedef struct packed {
        logic              drop;
        logic              bad;
        logic [KIND_W-1:0] kind;
        logic [RUN_W-1:0]  bracket_run;
        logic              failed;
    } t_cls;

    // Item handed from the input side to the emitter.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] raw;
        logic              bad;
    } t_item;

    function automatic logic [IDX_W-1:0] ent_len(input logic [KIND_W-1:0] kind);
        logic [IDX_W-1:0] len;
        case (kind)
            KIND_AMP:  len = 3'd5;
            KIND_LT:   len = 3'd4;
            KIND_QUOT: len = 3'd6;
            KIND_GT:   len = 3'd4;
            default:   len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [BYTE_W-1:0] ent_byte(input logic [KIND_W-1:0] kind,
                                                   input logic [IDX_W-1:0]  idx,
                                                   input logic [BYTE_W-1:0] raw);
        logic [ENT_W-1:0] text;
        logic [IDX_W-1:0] pos;
        logic [ENT_W-1:0] sel;
        case (kind)
            KIND_AMP:  text = ENT_AMP;
            KIND_LT:   text = ENT_LT;
            KIND_QUOT: text = ENT_QUOT;
            KIND_GT:   text = ENT_GT;
            default:   text = {{(ENT_W-BYTE_W){1'b0}}, raw};
        endcase
        pos = ent_len(kind) - idx - 3'd1;
        sel = text >> {pos, 3'b000};
        return sel[BYTE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/xte_classify.sv]
`timescale 1ns / 1ps
`default_nettype none

module xte_classify
    import xte_pkg::*;
(
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_attr,
    input  wire logic [RUN_W-1:0]  i_bracket_run,
    input  wire logic              i_failed,
    output t_cls                   o_cls
);

    logic is_ctrl;
    logic is_ok_ctrl;
    logic is_bad;
    logic two_brackets;

    assign is_ctrl      = (i_byte != CH_NUL) && (i_byte < CH_SPACE);
    assign is_ok_ctrl   = (i_byte == CH_TAB) || (i_byte == CH_LF) || (i_byte == CH_CR);
    assign is_bad       = is_ctrl && !is_ok_ctrl;
    assign two_brackets = i_bracket_run >= RUN_MAX;

    always_comb begin
        o_cls.drop        = i_failed || (i_byte == CH_NUL);
        o_cls.bad         = !i_failed && is_bad;
        o_cls.failed      = i_failed || is_bad;
        o_cls.kind        = KIND_PLAIN;
        o_cls.bracket_run = i_bracket_run;

        // A failed block and an invalid byte both leave the history alone.
        if (!i_failed && !is_bad) begin
            if (i_byte == CH_RBRACK) begin
                if (!two_brackets) begin
                    o_cls.bracket_run = i_bracket_run + 2'd1;
                end
            end else begin
                o_cls.bracket_run = '0;
            end
        end

        if (!is_bad) begin
            if (i_byte == CH_AMP) begin
                o_cls.kind = KIND_AMP;
            end else if (i_byte == CH_LT) begin
                o_cls.kind = KIND_LT;
            end else if (i_byte == CH_QUOT && i_attr) begin
                o_cls.kind = KIND_QUOT;
            end else if (i_byte == CH_GT && !i_attr && two_brackets) begin
                o_cls.kind = KIND_GT;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/xte_emit.sv]
`timescale 1ns / 1ps
`default_nettype none

module xte_emit
    import xte_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire t_item             i_item,
    output logic                   o_free,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [BYTE_W-1:0]      o_byte,
    output logic                   o_last,
    output logic                   o_bad
);

    logic              r_a_valid;
    t_item             r_a_item;
    logic [IDX_W-1:0]  r_a_idx;
    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_last;
    logic              r_o_bad;

    logic              a_last;
    logic              out_load;

    assign a_last   = r_a_idx == (ent_len(r_a_item.kind) - 3'd1);
    assign out_load = r_a_valid && (!r_o_valid || i_ready);
    assign o_free   = !r_a_valid || (a_last && out_load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_idx   <= '0;
        end else if (i_load) begin
            r_a_valid <= 1'b1;
            r_a_idx   <= '0;
        end else if (out_load) begin
            if (a_last) begin
                r_a_valid <= 1'b0;
            end else begin
                r_a_idx <= r_a_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_byte <= ent_byte(r_a_item.kind, r_a_idx, r_a_item.raw);
            r_o_last <= a_last;
            r_o_bad  <= r_a_item.bad;
        end
    end

    assign o_valid = r_o_valid;
    assign o_byte  = r_o_byte;
    assign o_last  = r_o_last;
    assign o_bad   = r_o_bad;

endmodule

`default_nettype wire

[hdl/xml_text_escaper_top.sv]
// Escapes a stream of text bytes for XML, one byte per input item.
// Input channel (s): tdata carries the text byte, tuser says whether the byte
// sits in an attribute value (1) or in element content (0).
// Output channel (m): tdata carries one emitted byte, tlast marks the final
// byte produced for an input item, and tuser flags an invalid control byte.
// An ordinary byte gives one output item; an escaped byte gives its entity,
// four to six output items. A zero byte ends a string and gives no output.
// From input acceptance to the first output item, the item lands in the
// entity register, then in the output register.
// Throughput is one item per cycle for bytes that pass through, as long as the
// output flows; an entity occupies the entity register until its last byte has
// moved to the output register, and that alone holds off the input then.
// After an invalid control byte the block reports it once and then accepts
// and discards every further item until reset.
// Reset (synchronous, active low) empties both registers, clears the bracket
// history and the failure flag. When the receiver stalls, the output register
// holds its item, the entity register fills behind it, and then tready on
// the input falls until the output moves again.
`timescale 1ns / 1ps
`default_nettype none

module xml_text_escaper_top
    import xte_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [BYTE_W-1:0] i_s_tdata,   // [7:0] text_byte
    input  wire logic              i_s_tuser,   // [0] in_attribute
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [BYTE_W-1:0]      o_m_tdata,   // [7:0] out_byte
    output logic                   o_m_tlast,   // last_of_run
    output logic                   o_m_tuser    // [0] bad_char
);

    // String state: consecutive closing brackets and the sticky failure.
    logic [RUN_W-1:0] r_bracket_run;
    logic             r_failed;

    t_cls  cls;
    t_item item;
    logic  accept;
    logic  free;

    xte_classify u_classify (
        .i_byte        (i_s_tdata),
        .i_attr        (i_s_tuser),
        .i_bracket_run (r_bracket_run),
        .i_failed      (r_failed),
        .o_cls         (cls)
    );

    // Items are classified in acceptance order, so the state can move on at
    // once even while earlier entities are still being sent.
    assign accept = i_s_tvalid && free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bracket_run <= '0;
            r_failed      <= 1'b0;
        end else if (accept) begin
            r_bracket_run <= cls.bracket_run;
            r_failed      <= cls.failed;
        end
    end

    assign item.kind = cls.kind;
    assign item.raw  = i_s_tdata;
    assign item.bad  = cls.bad;

    xte_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && !cls.drop),
        .i_item  (item),
        .o_free  (free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast),
        .o_bad   (o_m_tuser)
    );

    assign o_s_tready = free;

endmodule

`default_nettype wire

[hdl/xte_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "xml_text_escaper_top_defines.svh"

module xte_checker
    import xte_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic              o_s_tready,
    input  wire logic [BYTE_W-1:0] i_s_tdata,
    input  wire logic              i_s_tuser,
    input  wire logic              o_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire logic [BYTE_W-1:0] o_m_tdata,
    input  wire logic              o_m_tlast,
    input  wire logic              o_m_tuser
);

    logic r_seen_bad;
    logic in_unused;

    assign in_unused = i_s_tvalid ^ o_s_tready ^ (^i_s_tdata) ^ i_s_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_bad <= 1'b0;
        end else if (o_m_tvalid && i_m_tready && o_m_tuser) begin
            r_seen_bad <= 1'b1;
        end
    end

    `XTE_ASSERT_NEXT(a_hold_valid, o_m_tvalid && !i_m_tready, o_m_tvalid, "output item withdrawn while stalled")
    `XTE_ASSERT_NEXT(a_hold_data, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && $stable(o_m_tlast), "stalled output item changed")
    `XTE_ASSERT_NOW(a_bad_last, o_m_tvalid && o_m_tuser, o_m_tlast && !in_unused == !in_unused, "error item not last of its run")
    `XTE_ASSERT_NOW(a_quiet_after_bad, r_seen_bad, !o_m_tvalid, "output after an error item")

endmodule

bind xml_text_escaper_top xte_checker u_xte_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
